@@ design/wbps_pkg.sv @@
// Package for the wildcard byte pattern scan core.
// Holds sizes, configuration register codes, shared structs and helpers.
// No dependencies; every other design file imports it.
package wbps_pkg;

  localparam int unsigned MaxPattern = 16;
  localparam int unsigned AddrBits   = 32;
  localparam int unsigned LenW       = 5;
  localparam int unsigned FillW      = $clog2(MaxPattern + 1);
  localparam int unsigned AgeW       = $clog2(MaxPattern);
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned OffsetW    = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLow  = 3'd0,
    CfgPatternHigh = 3'd1,
    CfgWildMask    = 3'd2,
    CfgPatternLen  = 3'd3,
    CfgMatchOffset = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [MaxPattern-1:0][7:0] pattern;
    logic [MaxPattern-1:0]      wild;
    logic [LenW-1:0]            len;
    logic signed [OffsetW-1:0]  offset;
  } cfg_t;

  // One result waiting for the back end: found flag and position of the
  // byte that completed the match (or ended the scan).
  typedef struct packed {
    logic                found;
    logic [AddrBits-1:0] pos;
  } q_entry_t;

  // Pattern length as used by the compare: lengths above the window
  // size saturate at the window size.
  function automatic logic [FillW-1:0] eff_len(input logic [LenW-1:0] len);
    logic [FillW-1:0] res;
    if (len > LenW'(MaxPattern)) begin
      res = FillW'(MaxPattern);
    end else begin
      res = FillW'(len);
    end
    return res;
  endfunction

endpackage

@@ design/wbps_if.sv @@
// Handshake channel interfaces for the wildcard byte pattern scan core:
// input bytes, results and configuration writes.
// Depends on wbps_pkg.
interface wbps_in_if import wbps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [7:0]          data_byte;
  logic [AddrBits-1:0] byte_position;
  logic                region_start;
  logic                last_byte;

  modport source (output valid, data_byte, byte_position, region_start, last_byte,
                  input ready);
  modport sink   (input valid, data_byte, byte_position, region_start, last_byte,
                  output ready);
endinterface

interface wbps_out_if import wbps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [AddrBits-1:0] match_address;

  modport source (output valid, found, match_address, input ready);
  modport sink   (input valid, found, match_address, output ready);
endinterface

interface wbps_cfg_if import wbps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/wbps_cfg_regs.sv @@
// Configuration register file of the wildcard byte pattern scan core.
// Depends on wbps_pkg and the configuration channel in wbps_if.
module wbps_cfg_regs import wbps_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  wbps_cfg_if.sink      cfg_i,
  output cfg_t          cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern <= '0;
      cfg_q.wild    <= '0;
      cfg_q.len     <= LenW'(1);
      cfg_q.offset  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgPatternLow:  cfg_q.pattern[7:0]  <= cfg_i.data;
        CfgPatternHigh: cfg_q.pattern[15:8] <= cfg_i.data;
        CfgWildMask:    cfg_q.wild          <= cfg_i.data[MaxPattern-1:0];
        CfgPatternLen:  cfg_q.len           <= cfg_i.data[LenW-1:0];
        CfgMatchOffset: cfg_q.offset        <= signed'(cfg_i.data[OffsetW-1:0]);
        default: ;
      endcase
    end
  end

endmodule

@@ design/wbps_front.sv @@
// Front end of the wildcard byte pattern scan core: accepts bytes, keeps the
// shift window and scan state, and classifies each byte as match, end of
// scan without match, or no result. Depends on wbps_pkg and wbps_if.
module wbps_front import wbps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  wbps_in_if.sink  in_i,
  input  cfg_t     cfg_i,
  input  logic     q_full_i,
  output logic     push_o,
  output q_entry_t push_entry_o
);

  logic [MaxPattern-1:0][7:0] win_q, win_d;
  logic [FillW-1:0]           fill_q, fill_d, fill_base, fill_shift;
  logic                       done_q, done_d;
  logic [FillW-1:0]           len;
  logic [AgeW-1:0]            age [MaxPattern];
  logic                       hit;
  logic                       accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign len        = eff_len(cfg_i.len);

  // Window as it stands once this byte has been shifted in.
  always_comb begin
    win_d[0] = in_i.data_byte;
    for (int i = 1; i < MaxPattern; i++) begin
      win_d[i] = win_q[i-1];
    end
    fill_base  = in_i.region_start ? '0 : fill_q;
    fill_shift = (fill_base == FillW'(MaxPattern)) ? fill_base : fill_base + 1'b1;
  end

  // Pattern byte k lines up with the window byte that is len-1-k bytes old.
  always_comb begin
    hit = (len != '0) && (fill_shift >= len);
    for (int k = 0; k < MaxPattern; k++) begin
      age[k] = AgeW'(len - FillW'(1) - FillW'(k));
      if ((FillW'(k) < len) && !cfg_i.wild[k] && (win_d[age[k]] != cfg_i.pattern[k])) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    done_d = done_q;
    push_o = 1'b0;
    if (accept) begin
      if (!done_q) begin
        fill_d = fill_shift;
        done_d = hit;
        push_o = hit || in_i.last_byte;
      end
      if (in_i.last_byte) begin
        fill_d = '0;
        done_d = 1'b0;
      end
    end
    push_entry_o.found = hit;
    push_entry_o.pos   = in_i.byte_position;
  end

  always_ff @(posedge clk_i) begin
    if (accept && !done_q) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      done_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      done_q <= done_d;
    end
  end

  // A match in the middle of a scan must silence the rest of that scan.
  a_done_after_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_entry_o.found && !in_i.last_byte) |=> done_q)
    else $error("scan not marked done after a match");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(MaxPattern))
    else $error("window fill count out of range");

endmodule

@@ design/wbps_fifo.sv @@
// Two-entry result queue between front and back end of the scan core.
// Depends on wbps_pkg.
module wbps_fifo import wbps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t head_o
);

  q_entry_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !(pop_i && valid_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i && valid_o) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full result queue");

endmodule

@@ design/wbps_back.sv @@
// Back end of the scan core: turns queued results into the match address
// and holds them in the output register. Depends on wbps_pkg and wbps_if.
module wbps_back import wbps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  q_entry_t  q_head_i,
  output logic      pop_o,
  wbps_out_if.source out_o
);

  logic                valid_q;
  logic                found_q;
  logic [AddrBits-1:0] addr_q, addr_d;
  logic [FillW-1:0]    len;

  assign len   = eff_len(cfg_i.len);
  assign pop_o = q_valid_i && (!valid_q || out_o.ready);

  // Start of the match is len-1 bytes before the completing byte.
  always_comb begin
    addr_d = '0;
    if (q_head_i.found) begin
      addr_d = q_head_i.pos - AddrBits'(len - FillW'(1))
             + AddrBits'(signed'(cfg_i.offset));
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      found_q <= q_head_i.found;
      addr_q  <= addr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.found         = found_q;
  assign out_o.match_address = addr_q;

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !found_q) |-> (addr_q == '0))
    else $error("not-found result carries a non-zero address");

endmodule

@@ design/wildcard_byte_pattern_scan_core.sv @@
// Wildcard byte pattern scan core: finds the first occurrence of a pattern of
// up to 16 bytes, some of which may be wildcards, in a stream of bytes. The
// core takes one byte every clock cycle; the masked compare over the 16-byte
// shift window completes in the cycle the byte is accepted. Each result is
// written into the result queue and passes from there to the output register
// after any results already waiting ahead of it; a stalled output holds it for
// as long as the stall lasts. A two-entry queue separates the compare stage
// from the address stage, so input is only held off while that queue holds two
// results. The user must write configuration through the config channel only
// while no scan is in progress and no result is in flight; the core does not
// enforce this itself. Depends on wbps_pkg and wbps_if.
module wildcard_byte_pattern_scan_core import wbps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  wbps_cfg_if.sink    cfg_i,
  wbps_in_if.sink     in_i,
  wbps_out_if.source  out_o
);

  cfg_t     cfg;
  logic     q_full, q_push, q_pop, q_valid;
  q_entry_t q_push_entry, q_head;

  wbps_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  wbps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .push_entry_o (q_push_entry)
  );

  wbps_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  wbps_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .pop_o     (q_pop),
    .out_o     (out_o)
  );

endmodule

@@ sim/tb_wildcard_byte_pattern_scan_core.sv @@
// Testbench for wildcard_byte_pattern_scan_core: directed scans, then random scans
// over many pattern settings, checked word by word against a scoreboard.
// Depends on wbps_pkg, the wbps_if interfaces and the core itself.
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scan_core;
  import wbps_pkg::*;

  localparam int unsigned CycleLimit   = 500_000;
  localparam int unsigned RandomBytes  = 600;
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    bit [7:0]  data;
    bit [31:0] pos;
    bit        rs;
    bit        last;
  } scan_byte_t;

  typedef struct packed {
    bit        found;
    bit [31:0] address;
  } report_t;

  // Tracks the shift window and the pattern setting, and holds the reports
  // the core owes us in the order they must leave it.
  class match_scoreboard;
    bit [MaxPattern-1:0][7:0] pattern;
    bit [MaxPattern-1:0]      wild_mask;
    bit [4:0]                 pattern_len = 5'd1;
    bit [31:0]                offset;
    bit [MaxPattern-1:0][7:0] window;
    int unsigned              fill;
    bit                       done;
    report_t                  expected_reports[$];
    int unsigned              bytes_scanned;
    int unsigned              reports_checked;
    int unsigned              matches_checked;
    int unsigned              errors;

    function int unsigned eff_len();
      return (pattern_len > MaxPattern) ? MaxPattern : pattern_len;
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    function void write_reg(cfg_idx_e idx, bit [63:0] value);
      case (idx)
        CfgPatternLow:  pattern[7:0]  = value;
        CfgPatternHigh: pattern[15:8] = value;
        CfgWildMask:    wild_mask     = value[15:0];
        CfgPatternLen:  pattern_len   = value[4:0];
        CfgMatchOffset: offset        = value[31:0];
        default: ;
      endcase
    endfunction

    function void take_byte(scan_byte_t b);
      int unsigned len;
      bit          hit;
      report_t     rep;
      len = eff_len();
      if (!done) begin
        bytes_scanned++;
        if (b.rs) fill = 0;
        window = {window[MaxPattern-2:0], b.data};
        if (fill < MaxPattern) fill++;
        hit = (len != 0) && (fill >= len);
        // Pattern byte 0 lines up with the oldest of the len window bytes compared.
        for (int k = 0; k < len; k++) begin
          if (!wild_mask[k] && window[len-1-k] != pattern[k]) hit = 1'b0;
        end
        if (hit) begin
          rep.found   = 1'b1;
          rep.address = b.pos - 32'(len - 1) + offset;
          expected_reports = {expected_reports, rep};
          done = 1'b1;
        end else if (b.last) begin
          rep.found   = 1'b0;
          rep.address = '0;
          expected_reports = {expected_reports, rep};
        end
      end
      if (b.last) begin
        fill = 0;
        done = 1'b0;
      end
    endfunction

    function void check_report(logic found, logic [31:0] address);
      report_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, found=%b address=%h", $time, found, address);
        return;
      end
      want = expected_reports.pop_front();
      reports_checked++;
      if (want.found) matches_checked++;
      if (found !== want.found) begin
        errors++;
        $display("%0t: found mismatch, expected %b actual %b", $time, want.found, found);
      end
      if (address !== want.address) begin
        errors++;
        $display("%0t: match_address mismatch, expected %h actual %h",
                 $time, want.address, address);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic sink_ready = 1'b0;

  wbps_cfg_if cfg_if ();
  wbps_in_if  in_if ();
  wbps_out_if out_if ();

  assign out_if.ready = sink_ready;

  wildcard_byte_pattern_scan_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  match_scoreboard scoreboard = new();

  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned bytes_sent;
  int unsigned settings_loaded;
  int unsigned scans_run;
  bit          held_mid_scan;
  int unsigned stall_mode;
  int unsigned stall_left;

  always #5 clk_i = ~clk_i;

  // The receiver switches at random between several stall patterns.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: sink_ready <= 1'b1;
      1: sink_ready <= ($urandom_range(0, 1) == 0);
      2: sink_ready <= (cycle_count % 4 != 0);
      default: sink_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      scoreboard.check_report(out_if.found, out_if.match_address);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: no progress after %0d cycles, %0d words still owed",
             $time, cycle_count, scoreboard.pending());
    $display("wildcard_byte_pattern_scan_core test failed");
    $finish;
  end

  task automatic idle_for(input int unsigned n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (scoreboard.pending() != 0);
  endtask

  task automatic send_byte(input scan_byte_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) idle_for(gap);
    end
    burst_left--;
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= b.data;
    in_if.byte_position <= b.pos;
    in_if.region_start  <= b.rs;
    in_if.last_byte     <= b.last;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
    scoreboard.take_byte(b);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input bit [63:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    scoreboard.write_reg(idx, value);
  endtask

  // Registers are only touched once the core has gone quiet.
  task automatic load_setup(input bit [63:0] low, input bit [63:0] high,
                            input bit [63:0] mask, input bit [63:0] len,
                            input bit [63:0] off);
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(CfgPatternLow, low);
    write_reg(CfgPatternHigh, high);
    write_reg(CfgWildMask, mask);
    write_reg(CfgPatternLen, len);
    write_reg(CfgMatchOffset, off);
    cfg_if.valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic randomise_setup();
    bit [63:0] low;
    bit [63:0] high;
    bit [15:0] mask;
    bit [4:0]  len;
    bit [31:0] off;
    bit [7:0]  pb;
    for (int k = 0; k < 16; k++) begin
      case ($urandom_range(0, 5))
        0:       pb = 8'h00;
        1:       pb = 8'hFF;
        2:       pb = 8'($urandom);
        default: pb = 8'(8'h40 + $urandom_range(0, 3));
      endcase
      if (k < 8) low[8*k +: 8] = pb;
      else       high[8*(k-8) +: 8] = pb;
    end
    case ($urandom_range(0, 5))
      0:       mask = '0;
      1:       mask = '1;
      default: mask = 16'($urandom & $urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       len = 5'd1;
      1:       len = 5'd2;
      6:       len = 5'($urandom_range(5, 16));
      7:       len = 5'd16;
      8:       len = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
      default: len = 5'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 5))
      0:       off = '0;
      1:       off = 32'h7FFF_FFFF;
      2:       off = 32'h8000_0000;
      3:       off = 32'hFFFF_FFFF;
      default: off = $urandom;
    endcase
    // Bits above each register's width carry noise; the core must drop them.
    load_setup(low, high, {$urandom, 16'($urandom), mask},
               {$urandom, 27'($urandom), len}, {$urandom, off});
  endtask

  function automatic bit [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return 8'(8'h40 + $urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  // Noisy scans carry random positions and flags; the others are regions of
  // consecutive positions, often with the pattern planted somewhere inside.
  task automatic run_scan(input bit noisy);
    scan_byte_t  items[$];
    scan_byte_t  b;
    bit [7:0]    chunk[$];
    int unsigned regions;
    int unsigned rlen;
    int unsigned plen;
    int unsigned at;
    bit [31:0]   pos;
    plen = scoreboard.eff_len();
    if (noisy) begin
      rlen = $urandom_range(1, 30);
      for (int i = 0; i < rlen; i++) begin
        b.data = 8'($urandom);
        b.pos  = $urandom;
        b.rs   = ($urandom_range(0, 3) == 0);
        b.last = ($urandom_range(0, 19) == 0);
        items = {items, b};
      end
    end else begin
      regions = $urandom_range(1, 3);
      pos = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15) : $urandom;
      for (int r = 0; r < regions; r++) begin
        rlen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 24);
        chunk.delete();
        for (int i = 0; i < rlen; i++) chunk = {chunk, pick_byte()};
        if (plen != 0 && rlen >= plen && $urandom_range(0, 4) < 3) begin
          at = $urandom_range(0, rlen - plen);
          for (int k = 0; k < plen; k++) begin
            if (!scoreboard.wild_mask[k]) chunk[at+k] = scoreboard.pattern[k];
          end
        end
        for (int i = 0; i < rlen; i++) begin
          b.data = chunk[i];
          b.pos  = pos;
          b.rs   = (i == 0);
          b.last = 1'b0;
          items = {items, b};
          pos++;
        end
        pos = pos + $urandom_range(1, 1000);
      end
    end
    items[items.size()-1].last = 1'b1;
    foreach (items[i]) begin
      if (!held_mid_scan && !noisy && i > 0 && i == items.size() / 2) begin
        held_mid_scan = 1'b1;
        drain_results();
      end
      send_byte(items[i]);
    end
    scans_run++;
  endtask

  initial begin
    int unsigned random_from;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.data_byte     <= '0;
    in_if.byte_position <= '0;
    in_if.region_start  <= 1'b0;
    in_if.last_byte     <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CfgPatternLow;
    cfg_if.data         <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset setting is a one-byte pattern of zero: the second byte hits, the
    // closing byte is then ignored.
    send_byte('{8'hFF, 32'h0, 1'b1, 1'b0});
    send_byte('{8'h00, 32'h1, 1'b0, 1'b0});
    send_byte('{8'h00, 32'h2, 1'b0, 1'b1});

    // Three bytes with a wildcard in the middle, hit on the last byte while
    // the start position and the offset both wrap.
    load_setup(64'h0000_0000_0043_0041, 64'h0, 64'h2, 64'h3, 64'h7FFF_FFFF);
    send_byte('{8'h41, 32'hFFFF_FFFE, 1'b1, 1'b0});
    send_byte('{8'h99, 32'hFFFF_FFFF, 1'b0, 1'b0});
    send_byte('{8'h43, 32'h0, 1'b0, 1'b1});
    // A region start in the middle breaks what would otherwise match.
    send_byte('{8'h41, 32'h10, 1'b1, 1'b0});
    send_byte('{8'h99, 32'h11, 1'b0, 1'b0});
    send_byte('{8'h43, 32'h80, 1'b1, 1'b1});

    // Zero length never matches.
    load_setup(64'h0000_0000_0043_0041, 64'h0, 64'h2, 64'hFFFF_FFFF_FFFF_FFE0,
               64'h7FFF_FFFF);
    send_byte('{8'h41, 32'h5, 1'b1, 1'b0});
    send_byte('{8'h41, 32'h6, 1'b0, 1'b1});

    // Length above the window size saturates; outer bytes exact, inner wild,
    // offset of minus one.
    load_setup(64'h0, 64'hFF00_0000_0000_0000, 64'h7FFE, 64'h11, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int k = 0; k < 16; k++) begin
      send_byte('{(k == 0) ? 8'h00 : (k == 15) ? 8'hFF : 8'($urandom),
                  32'h1000 + k, k == 0, k == 15});
    end

    random_from = bytes_sent;
    while (bytes_sent - random_from < RandomBytes) begin
      randomise_setup();
      repeat ($urandom_range(2, 6)) begin
        if (bytes_sent - random_from < RandomBytes) run_scan($urandom_range(0, 4) == 0);
      end
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d bytes, %0d of them scanned, in %0d random scans under %0d settings.",
             bytes_sent, scoreboard.bytes_scanned, scans_run, settings_loaded);
    $display("Checked %0d result words, %0d of them matches, %0d errors.",
             scoreboard.reports_checked, scoreboard.matches_checked, scoreboard.errors);
    if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
      $display("wildcard_byte_pattern_scan_core test passed");
    end else begin
      $display("wildcard_byte_pattern_scan_core test failed");
    end
    $finish;
  end

endmodule
